/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define UER_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("uer assertion failed");

// Clocked assertion that also holds through reset.
`define UER_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("uer assertion failed");

`endif

/* hw/rtl/uer_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_pkg
// Widths, register indexes and reset values of the echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

   localparam int TICK_WIDTH = 16;                 // echo timer width
   localparam int RT_W       = 16;                 // round tick counter
   localparam int SUM_W      = TICK_WIDTH + 4;     // up to 15 rounds of captures
   localparam int DVS_W      = 8;                  // divider divisor width
   localparam int DIST_W     = 16;
   localparam int CNT_W      = $clog2(SUM_W + 1);
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DAT_W  = 16;

   localparam logic [TICK_WIDTH-1:0] ECHO_MAX = {TICK_WIDTH{1'b1}};
   localparam logic [DIST_W-1:0]     DIST_MAX = {DIST_W{1'b1}};

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TRIGGER_TICKS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_TICKS  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TICKS_PER_CM  = 2'd3;

   // register reset values
   localparam logic [3:0]  RST_SAMPLE_COUNT  = 4'd10;
   localparam logic [7:0]  RST_TRIGGER_TICKS = 8'd15;
   localparam logic [15:0] RST_WINDOW_TICKS  = 16'd60000;
   localparam logic [7:0]  RST_TICKS_PER_CM  = 8'd58;

endpackage

/* hw/rtl/uer_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_if
// Valid/ready channels of the echo ranger: tick input, result, register write.
// ----------------------------------------------------------------------------
interface uer_req_if;
   logic valid;
   logic ready;
   logic start_req;
   logic echo_level;

   modport source (output valid, start_req, echo_level, input ready);
   modport sink   (input valid, start_req, echo_level, output ready);
endinterface

interface uer_rsp_if;
   import uer_pkg::*;
   logic              valid;
   logic              ready;
   logic              trigger_out;
   logic              busy_res;
   logic              done_res;
   logic [DIST_W-1:0] distance_cm;

   modport source (output valid, trigger_out, busy_res, done_res, distance_cm,
                   input ready);
   modport sink   (input valid, trigger_out, busy_res, done_res, distance_cm,
                   output ready);
endinterface

interface uer_csr_if;
   import uer_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/ultrasonic_echo_ranger_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_core
// Ultrasonic ranging sequencer: trigger pulse, echo timing, averaged distance.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one transaction per microsecond tick (start request and
//   sampled echo level); rsp_ch returns exactly one transaction per tick with
//   the trigger level, busy, done and the averaged distance in cm.
//   csr_ch writes the four setup registers (sample count, trigger ticks,
//   window ticks, ticks per cm); write them only while no tick is in flight.
//   Each accepted tick passes through S_EMIT to the output register. A tick
//   that closes a round first runs one serial division of the echo count
//   in S_DIV1; the last round of a measurement adds a second serial
//   division for the average in S_DIV2, both on the bit-serial divider.
//   A new tick is accepted once the previous one has been written to the
//   output register, even if the receiver has not yet taken that result;
//   with rsp_ch stalled the next result waits until the register frees up.
//   Reset returns the registers to their defaults and the sequencer to idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ultrasonic_echo_ranger_core (
   input  logic clock,
   input  logic reset,
   uer_req_if.sink   req_ch,
   uer_rsp_if.source rsp_ch,
   uer_csr_if.sink   csr_ch
);
   import uer_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV1 = 2'd1;
   localparam logic [1:0] S_DIV2 = 2'd2;
   localparam logic [1:0] S_EMIT = 2'd3;

   // setup registers
   logic [3:0]  sample_count_ff;
   logic [7:0]  trigger_ticks_ff;
   logic [15:0] window_ticks_ff;
   logic [7:0]  ticks_per_cm_ff;

   // sequencer state
   logic [1:0]            state_ff, state_in;
   logic                  phase_ff, phase_in;
   logic [RT_W-1:0]       round_tick_ff, round_tick_in;
   logic [3:0]            round_index_ff, round_index_in;
   logic                  edge_toggle_ff, edge_toggle_in;
   logic                  echo_prev_ff, echo_prev_in;
   logic [TICK_WIDTH-1:0] echo_timer_ff, echo_timer_in;
   logic [TICK_WIDTH-1:0] captured_ff, captured_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic                  last_ff, last_in;

   // pending result and output register
   logic              pend_trig_ff, pend_trig_in;
   logic              pend_busy_ff, pend_busy_in;
   logic              pend_done_ff, pend_done_in;
   logic [DIST_W-1:0] pend_dist_ff, pend_dist_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_trig_ff, rsp_busy_ff, rsp_done_ff;
   logic [DIST_W-1:0] rsp_dist_ff;
   logic              rsp_load;

   // divider
   logic             div_start;
   logic [SUM_W-1:0] div_a;
   logic [DVS_W-1:0] div_b;
   logic             div_done;
   logic [SUM_W-1:0] div_q;

   // tick evaluation
   logic                  req_fire;
   logic                  echo_edge, start_now, run;
   logic [RT_W-1:0]       rt_b;
   logic                  tog_b, tog_n;
   logic [TICK_WIDTH-1:0] tmr_b, tmr_n, cap_b, cap_n;
   logic [3:0]            ridx_b;
   logic                  tmr_max, trig, round_end, last_round;
   logic [RT_W:0]         rt_inc;
   logic [4:0]            ridx_inc;
   logic [3:0]            rounds_eff;
   logic [15:0]           window_eff;
   logic [7:0]            tpc_eff;
   logic [SUM_W-1:0]      sum_acc;

   assign rounds_eff = (sample_count_ff == '0) ? 4'd1 : sample_count_ff;
   assign window_eff = (window_ticks_ff == '0) ? 16'd1 : window_ticks_ff;
   assign tpc_eff    = (ticks_per_cm_ff == '0) ? 8'd1 : ticks_per_cm_ff;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff  <= RST_SAMPLE_COUNT;
         trigger_ticks_ff <= RST_TRIGGER_TICKS;
         window_ticks_ff  <= RST_WINDOW_TICKS;
         ticks_per_cm_ff  <= RST_TICKS_PER_CM;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_SAMPLE_COUNT:  sample_count_ff  <= csr_ch.data[3:0];
            REG_TRIGGER_TICKS: trigger_ticks_ff <= csr_ch.data[7:0];
            REG_WINDOW_TICKS:  window_ticks_ff  <= csr_ch.data;
            REG_TICKS_PER_CM:  ticks_per_cm_ff  <= csr_ch.data[7:0];
            default: ;
         endcase
      end
   end

   // per-tick logic; a start request while idle rebases the round state to zero
   always_comb begin
      echo_edge = req_ch.echo_level ^ echo_prev_ff;
      start_now = !phase_ff && req_ch.start_req;
      run       = phase_ff || start_now;
      rt_b      = start_now ? '0 : round_tick_ff;
      tog_b     = start_now ? 1'b0 : edge_toggle_ff;
      tmr_b     = start_now ? '0 : echo_timer_ff;
      cap_b     = start_now ? '0 : captured_ff;
      ridx_b    = start_now ? '0 : round_index_ff;
      trig      = run && (rt_b < RT_W'(trigger_ticks_ff));
      tmr_max   = (tmr_b == ECHO_MAX);
      tog_n     = tog_b;
      tmr_n     = tmr_b;
      cap_n     = cap_b;
      if (echo_edge) begin
         if (!tog_b) begin
            tog_n = 1'b1;
            tmr_n = '0;
         end else begin
            tog_n = 1'b0;
            cap_n = tmr_max ? ECHO_MAX : tmr_b + TICK_WIDTH'(1);
         end
      end else if (tog_b && !tmr_max) begin
         tmr_n = tmr_b + TICK_WIDTH'(1);
      end
      rt_inc     = {1'b0, rt_b} + (RT_W+1)'(1);
      round_end  = run && (rt_inc >= {1'b0, window_eff});
      ridx_inc   = {1'b0, ridx_b} + 5'd1;
      last_round = ridx_inc >= {1'b0, rounds_eff};
   end

   assign sum_acc  = sum_ff + div_q;
   assign rsp_load = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      round_tick_in  = round_tick_ff;
      round_index_in = round_index_ff;
      edge_toggle_in = edge_toggle_ff;
      echo_prev_in   = echo_prev_ff;
      echo_timer_in  = echo_timer_ff;
      captured_in    = captured_ff;
      sum_in         = sum_ff;
      last_in        = last_ff;
      pend_trig_in   = pend_trig_ff;
      pend_busy_in   = pend_busy_ff;
      pend_done_in   = pend_done_ff;
      pend_dist_in   = pend_dist_ff;
      div_start      = 1'b0;
      div_a          = SUM_W'(cap_n);
      div_b          = tpc_eff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               echo_prev_in = req_ch.echo_level;
               pend_trig_in = trig;
               pend_busy_in = run && !(round_end && last_round);
               pend_done_in = 1'b0;
               pend_dist_in = '0;
               state_in     = S_EMIT;
               if (run) begin
                  phase_in = 1'b1;
                  sum_in   = start_now ? '0 : sum_ff;
                  if (!round_end) begin
                     round_tick_in  = rt_inc[RT_W-1:0];
                     round_index_in = ridx_b;
                     edge_toggle_in = tog_n;
                     echo_timer_in  = tmr_n;
                     captured_in    = cap_n;
                  end else begin
                     // round closes: scale this round's capture, then restart
                     round_tick_in  = '0;
                     edge_toggle_in = 1'b0;
                     echo_timer_in  = '0;
                     captured_in    = '0;
                     round_index_in = last_round ? 4'd0 : ridx_inc[3:0];
                     phase_in       = !last_round;
                     last_in        = last_round;
                     div_start      = 1'b1;
                     state_in       = S_DIV1;
                  end
               end
            end
         end
         S_DIV1: begin
            if (div_done) begin
               sum_in = sum_acc;
               if (last_ff) begin
                  div_start = 1'b1;
                  div_a     = sum_acc;
                  div_b     = DVS_W'(rounds_eff);
                  state_in  = S_DIV2;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_DIV2: begin
            if (div_done) begin
               pend_done_in = 1'b1;
               pend_dist_in = (div_q > SUM_W'(DIST_MAX)) ? DIST_MAX : div_q[DIST_W-1:0];
               state_in     = S_EMIT;
            end
         end
         S_EMIT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         phase_ff       <= 1'b0;
         round_tick_ff  <= '0;
         round_index_ff <= '0;
         edge_toggle_ff <= 1'b0;
         echo_prev_ff   <= 1'b0;
         echo_timer_ff  <= '0;
         captured_ff    <= '0;
         sum_ff         <= '0;
         last_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         round_tick_ff  <= round_tick_in;
         round_index_ff <= round_index_in;
         edge_toggle_ff <= edge_toggle_in;
         echo_prev_ff   <= echo_prev_in;
         echo_timer_ff  <= echo_timer_in;
         captured_ff    <= captured_in;
         sum_ff         <= sum_in;
         last_ff        <= last_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      pend_trig_ff <= pend_trig_in;
      pend_busy_ff <= pend_busy_in;
      pend_done_ff <= pend_done_in;
      pend_dist_ff <= pend_dist_in;
      if (state_ff == S_EMIT && rsp_load) begin
         rsp_trig_ff <= pend_trig_ff;
         rsp_busy_ff <= pend_busy_ff;
         rsp_done_ff <= pend_done_ff;
         rsp_dist_ff <= pend_dist_ff;
      end
   end

   uer_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.trigger_out = rsp_trig_ff;
   assign rsp_ch.busy_res    = rsp_busy_ff;
   assign rsp_ch.done_res    = rsp_done_ff;
   assign rsp_ch.distance_cm = rsp_dist_ff;

   `UER_ASSERT(a_done_not_busy, clock, reset,
      (rsp_ch.valid && rsp_ch.done_res) |-> !rsp_ch.busy_res)
   `UER_ASSERT(a_dist_only_done, clock, reset,
      (rsp_ch.valid && !rsp_ch.done_res) |-> (rsp_ch.distance_cm == '0))
   `UER_ASSERT(a_div_in_div_state, clock, reset,
      div_done |-> (state_ff == S_DIV1 || state_ff == S_DIV2))
   `UER_ASSERT_ALWAYS(a_accept_leaves_idle, clock,
      (!reset && req_ch.valid && req_ch.ready) |=> (reset || state_ff != S_IDLE))

endmodule

/* hw/rtl/uer_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_div
// Restoring divider, one quotient bit per cycle over the SUM_W dividend bits.
// ----------------------------------------------------------------------------
module uer_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [uer_pkg::SUM_W-1:0] dividend,
   input  logic [uer_pkg::DVS_W-1:0] divisor,
   output logic                      done,
   output logic [uer_pkg::SUM_W-1:0] quotient
);
   import uer_pkg::*;

   logic [SUM_W-1:0] dq_ff, dq_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   rem_sh;
   logic [DVS_W:0]   rem_sub;
   logic             ge;

   assign rem_sh  = {rem_ff, dq_ff[SUM_W-1]};
   assign ge      = rem_sh >= {1'b0, dvs_ff};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         dq_in  = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CNT_W'(SUM_W);
      end else if (cnt_ff != '0) begin
         dq_in   = {dq_ff[SUM_W-2:0], ge};
         rem_in  = ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule

/* dv/ultrasonic_echo_ranger_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_core_tb
// Self-checking bench for the echo ranger. Every tick transaction is run
// through a bit-accurate model of the ranging sequencer. Each result
// transaction is compared field by field with the oldest pending prediction.
// Stimulus is a short directed set of corner cases followed by random
// measurements, with random stalls on both channels and setup changes.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_core_tb;
   import uer_pkg::*;

   localparam int RANDOM_TICKS = 700;
   localparam int TAIL_TICKS   = 120;
   localparam int DRAIN_CYCLES = 60;
   localparam int CYCLE_LIMIT  = 1_000_000;

   typedef struct packed {
      logic              trigger;
      logic              busy;
      logic              done;
      logic [DIST_W-1:0] distance;
   } ranger_result_type;

   class ranging_scoreboard;
      logic [3:0]            rounds_cfg;
      logic [7:0]            trigger_cfg;
      logic [15:0]           window_cfg;
      logic [7:0]            per_cm_cfg;
      bit                    running;
      bit                    armed;
      bit                    echo_prev;
      logic [RT_W-1:0]       round_tick;
      logic [3:0]            round_idx;
      logic [TICK_WIDTH-1:0] echo_timer;
      logic [TICK_WIDTH-1:0] captured;
      logic [SUM_W-1:0]      dist_sum;
      ranger_result_type     pending_results[$];
      int                    fails;

      function new();
         rounds_cfg  = RST_SAMPLE_COUNT;
         trigger_cfg = RST_TRIGGER_TICKS;
         window_cfg  = RST_WINDOW_TICKS;
         per_cm_cfg  = RST_TICKS_PER_CM;
         running     = 0;
         round_idx   = '0;
         echo_prev   = 0;
         dist_sum    = '0;
         fails       = 0;
         start_round();
      endfunction

      function void start_round();
         round_tick = '0;
         armed      = 0;
         echo_timer = '0;
         captured   = '0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
         case (idx)
            REG_SAMPLE_COUNT:  rounds_cfg  = data[3:0];
            REG_TRIGGER_TICKS: trigger_cfg = data[7:0];
            REG_WINDOW_TICKS:  window_cfg  = data[15:0];
            REG_TICKS_PER_CM:  per_cm_cfg  = data[7:0];
            default: ;
         endcase
      endfunction

      // one accepted tick transaction -> one predicted result
      function void log_tick(bit start, bit echo);
         ranger_result_type r;
         bit                echo_edge;
         int unsigned       n_rounds, win, divisor, avg;
         n_rounds  = (rounds_cfg == 0) ? 1 : rounds_cfg;
         win       = (window_cfg == 0) ? 1 : window_cfg;
         divisor   = (per_cm_cfg == 0) ? 1 : per_cm_cfg;
         echo_edge = echo ^ echo_prev;
         echo_prev = echo;
         r = '0;
         if (!running && start) begin
            running   = 1;
            round_idx = '0;
            dist_sum  = '0;
            start_round();
         end
         if (running) begin
            r.trigger = (int'(round_tick) < int'(trigger_cfg));
            if (echo_edge) begin
               if (!armed) begin
                  armed      = 1;
                  echo_timer = '0;
               end else begin
                  armed    = 0;
                  captured = (echo_timer < ECHO_MAX) ? echo_timer + 1'b1 : ECHO_MAX;
               end
            end else if (armed && echo_timer < ECHO_MAX) begin
               echo_timer++;
            end
            if (int'(round_tick) + 1 >= win) begin
               dist_sum = dist_sum + SUM_W'(captured / divisor);
               if (int'(round_idx) + 1 >= n_rounds) begin
                  avg        = dist_sum / n_rounds;
                  r.distance = (avg > DIST_MAX) ? DIST_MAX : DIST_W'(avg);
                  r.done     = 1'b1;
                  running    = 0;
                  round_idx  = '0;
               end else begin
                  round_idx++;
                  start_round();
               end
            end else begin
               round_tick++;
            end
         end
         r.busy = running;
         pending_results.push_back(r);
      endfunction

      function string show(ranger_result_type v);
         return $sformatf("trig=%0b busy=%0b done=%0b dist=%0d",
                          v.trigger, v.busy, v.done, v.distance);
      endfunction

      function void flag(string msg);
         fails++;
         if (fails <= 10) $display("ERROR: %s", msg);
      endfunction

      function void check_result(ranger_result_type got);
         ranger_result_type want;
         if (pending_results.size() == 0) begin
            flag($sformatf("result with nothing pending: %s", show(got)));
            return;
         end
         want = pending_results.pop_front();
         if (got.trigger !== want.trigger || got.busy !== want.busy ||
             got.done !== want.done || got.distance !== want.distance)
            flag($sformatf("expected %s, got %s", show(want), show(got)));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   uer_req_if req_ch ();
   uer_rsp_if rsp_ch ();
   uer_csr_if csr_ch ();

   ultrasonic_echo_ranger_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   ranging_scoreboard sb = new();
   bit idle_on;
   int stall_left;
   int ticks_sent;
   int cycle_count;

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // result sink with random stall bursts
   always @(posedge clock) begin : rsp_sink
      ranger_result_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.trigger  = rsp_ch.trigger_out;
         got.busy     = rsp_ch.busy_res;
         got.done     = rsp_ch.done_res;
         got.distance = rsp_ch.distance_cm;
         sb.check_result(got);
      end
      if (stall_left > 0) stall_left--;
      else if (idle_on && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 18);
      rsp_ch.ready <= !reset && stall_left == 0;
   end

   task automatic send_tick(input bit start, input bit echo);
      int gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.start_req  <= start;
      req_ch.echo_level <= echo;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.log_tick(start, echo);
      ticks_sent++;
   endtask

   // no tick in flight once this returns
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      sb.set_reg(idx, data);
   endtask

   task automatic end_writes();
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic setup_regs(input logic [15:0] sc, input logic [15:0] tt,
                             input logic [15:0] wt, input logic [15:0] tpc);
      settle();
      write_reg(REG_SAMPLE_COUNT, sc);
      write_reg(REG_TRIGGER_TICKS, tt);
      write_reg(REG_WINDOW_TICKS, wt);
      write_reg(REG_TICKS_PER_CM, tpc);
      end_writes();
   endtask

   // narrow registers get random junk in the unused upper bits
   function automatic logic [CSR_DAT_W-1:0] reg_word(logic [CSR_IDX_W-1:0] idx,
                                                    int unsigned val);
      logic [CSR_DAT_W-1:0] junk;
      junk = CSR_DAT_W'($urandom);
      case (idx)
         REG_SAMPLE_COUNT: return {junk[15:4], val[3:0]};
         REG_WINDOW_TICKS: return val[15:0];
         default:          return {junk[15:8], val[7:0]};
      endcase
   endfunction

   task automatic random_setup();
      int          mode;
      int unsigned sc, tt, wt, tpc;
      mode = $urandom_range(0, 9);
      sc   = $urandom_range(0, 5);
      wt   = $urandom_range(0, 25);
      if (mode == 0) begin
         sc = 15;
         wt = $urandom_range(1, 3);
      end else if (mode == 1) begin
         sc = 1;
         wt = $urandom_range(100, 300);
      end
      tt = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 255 : 0)
                                       : $urandom_range(1, 12);
      tpc = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 6);
      setup_regs(reg_word(REG_SAMPLE_COUNT, sc), reg_word(REG_TRIGGER_TICKS, tt),
                 reg_word(REG_WINDOW_TICKS, wt), reg_word(REG_TICKS_PER_CM, tpc));
   endtask

   // start a measurement and feed ticks until the model says it is done
   task automatic run_measurement();
      int unsigned          pos, win, rise, fall, style, val;
      logic [CSR_IDX_W-1:0] idx;
      bit                   echo, first;
      first = 1;
      rise  = 0;
      fall  = 0;
      style = 0;
      do begin
         pos = first ? 0 : sb.round_tick;
         if (pos == 0) begin
            win   = (sb.window_cfg == 0) ? 1 : sb.window_cfg;
            style = $urandom_range(0, 9);
            rise  = $urandom_range(0, win - 1);
            fall  = $urandom_range(rise + 1, win);    // fall == win leaves it open
         end
         if (style <= 6)      echo = (pos >= rise && pos < fall);
         else if (style == 7) echo = 1'($urandom_range(0, 1));
         else if (style == 8) echo = 1'b0;
         else                 echo = 1'b1;
         send_tick(first || ($urandom_range(0, 15) == 0), echo);
         first = 0;
         // occasional setup change while the measurement is still running
         if (sb.running && $urandom_range(0, 59) == 0) begin
            idx = CSR_IDX_W'($urandom_range(0, 3));
            case (idx)
               REG_SAMPLE_COUNT: val = $urandom_range(0, 3);
               REG_WINDOW_TICKS: val = $urandom_range(0, 20);
               default:          val = $urandom_range(0, 255);
            endcase
            settle();
            write_reg(idx, reg_word(idx, val));
            end_writes();
         end
      end while (sb.running);
   endtask

   initial begin
      int rand_goal;
      req_ch.valid      = 1'b0;
      req_ch.start_req  = 1'b0;
      req_ch.echo_level = 1'b0;
      rsp_ch.ready      = 1'b0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = '0;
      csr_ch.data       = '0;
      idle_on     = 0;
      stall_left  = 0;
      ticks_sent  = 0;
      cycle_count = 0;
      repeat (4) @(posedge clock);
      reset   <= 1'b0;
      idle_on <= 1'b1;
      @(posedge clock);

      // echo edge on the start tick, start ignored while busy and on done tick
      setup_regs(16'h0001, 16'h0002, 16'h0004, 16'h0001);
      send_tick(1, 1);
      send_tick(1, 1);
      send_tick(0, 0);
      send_tick(1, 0);
      send_tick(0, 1);                  // idle echo is tracked but not timed
      send_tick(0, 0);
      // zero rounds, window and divisor all act as 1
      setup_regs(16'hFFF0, 16'hFF00, 16'h0000, 16'hFF00);
      send_tick(1, 1);
      send_tick(1, 0);
      // trigger longer than the window
      setup_regs(16'h0001, 16'h00FF, 16'h0003, 16'h00FF);
      send_tick(1, 0);
      send_tick(0, 1);
      send_tick(0, 0);
      // largest sample count and window, then shrink the window mid-measurement
      setup_regs(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001);
      send_tick(1, 1);
      send_tick(0, 1);
      send_tick(0, 0);
      send_tick(0, 1);
      settle();
      write_reg(REG_WINDOW_TICKS, 16'h0002);
      write_reg(REG_SAMPLE_COUNT, 16'h0001);
      end_writes();
      send_tick(0, 1);

      rand_goal = ticks_sent + RANDOM_TICKS;
      while (ticks_sent < rand_goal) begin
         if (ticks_sent > rand_goal - TAIL_TICKS) idle_on <= 1'b0;
         else idle_on <= ($urandom_range(0, 4) != 0);
         if ($urandom_range(0, 2) == 0) random_setup();
         repeat ($urandom_range(0, 3)) send_tick(0, 1'($urandom_range(0, 1)));
         run_measurement();
      end
      settle();

      if (sb.fails == 0 && sb.pending_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
